// File: design/dcsp_pkg.sv
`timescale 1ns / 1ps
// Shared types, character codes, phase and event encodings for the DIMACS CNF
// stream parser. No dependencies.
package dcsp_pkg;

	// Width of parsed numbers (variable index, clause counts).
	localparam int IndexBits = 31;
	// Width of the digit append sum: acc*10 + 9 fits in IndexBits+4 bits.
	localparam int AccExtBits = IndexBits + 4;
	// Width of the clause literal counter (saturating, fixed by the output field).
	localparam int LenBits = 31;

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_LC_C  = 8'h63;
	localparam logic [7:0] CH_LC_P  = 8'h70;
	localparam logic [7:0] CH_LC_N  = 8'h6E;
	localparam logic [7:0] CH_LC_F  = 8'h66;

	typedef enum logic [4:0] {
		PH_START   = 5'd0,
		PH_COMMENT = 5'd1,
		PH_H1      = 5'd2,
		PH_H2      = 5'd3,
		PH_H3      = 5'd4,
		PH_H4      = 5'd5,
		PH_H5      = 5'd6,
		PH_VFIRST  = 5'd7,
		PH_VNUM    = 5'd8,
		PH_CFIRST  = 5'd9,
		PH_CNUM    = 5'd10,
		PH_HTAIL   = 5'd11,
		PH_BODY    = 5'd12,
		PH_MINUS   = 5'd13,
		PH_LIT     = 5'd14,
		PH_DONE    = 5'd15,
		PH_ERR     = 5'd16
	} phase_t;

	typedef enum logic [2:0] {
		EV_NONE   = 3'd0,
		EV_LIT    = 3'd1,
		EV_CLAUSE = 3'd2,
		EV_HEADER = 3'd3,
		EV_FINISH = 3'd4,
		EV_ERROR  = 3'd5
	} event_t;

	localparam logic [3:0] ERR_NONE         = 4'd0;
	localparam logic [3:0] ERR_COMMENT_EOF  = 4'd1;
	localparam logic [3:0] ERR_HDR_SYNTAX   = 4'd2;
	localparam logic [3:0] ERR_HDR_ZERO     = 4'd3;
	localparam logic [3:0] ERR_HDR_OVF      = 4'd4;
	localparam logic [3:0] ERR_LIT_SYNTAX   = 4'd5;
	localparam logic [3:0] ERR_LIT_ZERO     = 4'd6;
	localparam logic [3:0] ERR_LIT_OVF      = 4'd7;
	localparam logic [3:0] ERR_RANGE        = 4'd8;
	localparam logic [3:0] ERR_TOO_MANY     = 4'd9;
	localparam logic [3:0] ERR_OPEN_CLAUSE  = 4'd10;
	localparam logic [3:0] ERR_MISSING      = 4'd11;
	localparam logic [3:0] ERR_HDR_EOF      = 4'd12;

	typedef struct packed {
		phase_t                 phase;
		logic [IndexBits-1:0]   acc;
		logic                   minus;
		logic [IndexBits-1:0]   decl_vars;
		logic [IndexBits-1:0]   decl_clauses;
		logic [IndexBits-1:0]   clauses_done;
		logic [LenBits-1:0]     lits;
		logic [3:0]             err;
	} parse_state_t;

	typedef struct packed {
		event_t       ev;
		logic [30:0]  variable;
		logic         negated;
		logic [30:0]  count;
		logic [3:0]   error_code;
	} parse_result_t;

	// Fit a number into the 31-bit output fields (zero extend or keep low bits).
	function automatic logic [30:0] fit_out(input logic [IndexBits-1:0] v);
		logic [IndexBits+31:0] w;
		w = {32'd0, v};
		return w[30:0];
	endfunction

endpackage

// File: design/dcsp_step.sv
`timescale 1ns / 1ps
// Next-state and result logic of the parser for one character beat.
// Depends on dcsp_pkg.
module dcsp_step import dcsp_pkg::*; (
	input  parse_state_t  cur,
	input  logic [7:0]    data_byte,
	input  logic          at_end,
	output parse_state_t  nxt,
	output parse_result_t res
);

	logic                  is_dig;
	logic                  is_ws;
	logic [3:0]            dig;
	logic [AccExtBits-1:0] ext;
	logic [AccExtBits-1:0] prod;
	logic                  ovf;
	logic                  acc_zero;
	logic [IndexBits-1:0]  done_inc;
	logic [IndexBits-1:0]  tail_clauses;
	logic                  tail_en;
	logic                  fail_en;
	logic [3:0]            fail_code;

	assign is_dig   = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign is_ws    = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
	                  (data_byte == CH_CR) || (data_byte == CH_NL);
	assign dig      = data_byte[3:0];
	assign ext      = {4'd0, cur.acc};
	// acc*10 + digit as two shifts and adds
	assign prod     = (ext << 3) + (ext << 1) + {{(AccExtBits-4){1'b0}}, dig};
	assign ovf      = |prod[AccExtBits-1:IndexBits];
	assign acc_zero = (cur.acc == '0);
	assign done_inc = cur.clauses_done + {{(IndexBits-1){1'b0}}, 1'b1};

	always_comb begin
		nxt          = cur;
		res          = '0;
		res.ev       = EV_NONE;
		fail_en      = 1'b0;
		fail_code    = ERR_NONE;
		tail_en      = 1'b0;
		tail_clauses = cur.decl_clauses;

		if (cur.phase == PH_ERR) begin
			res.ev         = EV_ERROR;
			res.error_code = cur.err;
		end else if (cur.phase == PH_DONE) begin
			res.ev = EV_NONE;
		end else if (cur.phase == PH_COMMENT) begin
			if (at_end) begin
				fail_en   = 1'b1;
				fail_code = ERR_COMMENT_EOF;
			end else if (data_byte == CH_NL) begin
				nxt.phase = PH_START;
			end
		end else if ((cur.phase < PH_BODY) && at_end) begin
			fail_en   = 1'b1;
			fail_code = ERR_HDR_EOF;
		end else begin
			case (cur.phase)
				PH_START: begin
					if (data_byte == CH_LC_C) nxt.phase = PH_COMMENT;
					else if (data_byte == CH_LC_P) nxt.phase = PH_H1;
					else begin fail_en = 1'b1; fail_code = ERR_HDR_SYNTAX; end
				end
				PH_H1: begin
					if (data_byte == CH_SPACE) nxt.phase = PH_H2;
					else begin fail_en = 1'b1; fail_code = ERR_HDR_SYNTAX; end
				end
				PH_H2: begin
					if (data_byte == CH_LC_C) nxt.phase = PH_H3;
					else begin fail_en = 1'b1; fail_code = ERR_HDR_SYNTAX; end
				end
				PH_H3: begin
					if (data_byte == CH_LC_N) nxt.phase = PH_H4;
					else begin fail_en = 1'b1; fail_code = ERR_HDR_SYNTAX; end
				end
				PH_H4: begin
					if (data_byte == CH_LC_F) nxt.phase = PH_H5;
					else begin fail_en = 1'b1; fail_code = ERR_HDR_SYNTAX; end
				end
				PH_H5: begin
					if (data_byte == CH_SPACE) nxt.phase = PH_VFIRST;
					else begin fail_en = 1'b1; fail_code = ERR_HDR_SYNTAX; end
				end
				PH_VFIRST, PH_CFIRST: begin
					if (!is_dig) begin
						fail_en   = 1'b1;
						fail_code = ERR_HDR_SYNTAX;
					end else begin
						nxt.acc   = {{(IndexBits-4){1'b0}}, dig};
						nxt.phase = (cur.phase == PH_VFIRST) ? PH_VNUM : PH_CNUM;
					end
				end
				PH_VNUM, PH_CNUM: begin
					if (is_dig) begin
						if (acc_zero) begin
							fail_en = 1'b1; fail_code = ERR_HDR_ZERO;
						end else if (ovf) begin
							fail_en = 1'b1; fail_code = ERR_HDR_OVF;
						end else begin
							nxt.acc = prod[IndexBits-1:0];
						end
					end else if (cur.phase == PH_VNUM) begin
						if (data_byte != CH_SPACE) begin
							fail_en = 1'b1; fail_code = ERR_HDR_SYNTAX;
						end else begin
							nxt.decl_vars = cur.acc;
							nxt.acc       = '0;
							nxt.phase     = PH_CFIRST;
						end
					end else begin
						nxt.decl_clauses = cur.acc;
						nxt.acc          = '0;
						nxt.phase        = PH_HTAIL;
						tail_clauses     = cur.acc;
						tail_en          = 1'b1;
					end
				end
				PH_HTAIL: begin
					tail_en = 1'b1;
				end
				PH_BODY: begin
					if (at_end) begin
						if (cur.lits != '0) begin
							fail_en = 1'b1; fail_code = ERR_OPEN_CLAUSE;
						end else if (cur.clauses_done < cur.decl_clauses) begin
							fail_en = 1'b1; fail_code = ERR_MISSING;
						end else begin
							nxt.phase = PH_DONE;
							res.ev    = EV_FINISH;
							res.count = fit_out(cur.clauses_done);
						end
					end else if (is_ws) begin
						nxt.phase = PH_BODY;
					end else if (data_byte == CH_MINUS) begin
						nxt.minus = 1'b1;
						nxt.phase = PH_MINUS;
					end else if (!is_dig) begin
						fail_en = 1'b1; fail_code = ERR_LIT_SYNTAX;
					end else begin
						nxt.acc   = {{(IndexBits-4){1'b0}}, dig};
						nxt.phase = PH_LIT;
					end
				end
				PH_MINUS: begin
					if (at_end || !is_dig || (data_byte == CH_ZERO)) begin
						fail_en = 1'b1; fail_code = ERR_LIT_SYNTAX;
					end else begin
						nxt.acc   = {{(IndexBits-4){1'b0}}, dig};
						nxt.phase = PH_LIT;
					end
				end
				PH_LIT: begin
					if (!at_end && is_dig) begin
						if (acc_zero) begin
							fail_en = 1'b1; fail_code = ERR_LIT_ZERO;
						end else if (ovf) begin
							fail_en = 1'b1; fail_code = ERR_LIT_OVF;
						end else begin
							nxt.acc = prod[IndexBits-1:0];
						end
					end else if (cur.acc > cur.decl_vars) begin
						fail_en = 1'b1; fail_code = ERR_RANGE;
					end else if (cur.clauses_done >= cur.decl_clauses) begin
						fail_en = 1'b1; fail_code = ERR_TOO_MANY;
					end else if (!at_end && !is_ws) begin
						fail_en = 1'b1; fail_code = ERR_LIT_SYNTAX;
					end else begin
						nxt.phase = PH_BODY;
						nxt.acc   = '0;
						nxt.minus = 1'b0;
						if (!acc_zero) begin
							if (at_end) begin
								fail_en = 1'b1; fail_code = ERR_OPEN_CLAUSE;
							end else begin
								res.ev       = EV_LIT;
								res.variable = fit_out(cur.acc);
								res.negated  = cur.minus;
								if (cur.lits != {LenBits{1'b1}}) begin
									nxt.lits = cur.lits + {{(LenBits-1){1'b0}}, 1'b1};
								end
							end
						end else begin
							// zero literal closes the clause
							nxt.clauses_done = done_inc;
							nxt.lits         = '0;
							if (at_end) begin
								if (done_inc < cur.decl_clauses) begin
									fail_en = 1'b1; fail_code = ERR_MISSING;
								end else begin
									nxt.phase = PH_DONE;
									res.ev    = EV_FINISH;
									res.count = fit_out(done_inc);
								end
							end else begin
								res.ev    = EV_CLAUSE;
								res.count = cur.lits;
							end
						end
					end
				end
				default: begin
					nxt = cur;
				end
			endcase
		end

		// header tail: blanks until newline, then report the header
		if (tail_en) begin
			if (data_byte == CH_NL) begin
				nxt.phase    = PH_BODY;
				res.ev       = EV_HEADER;
				res.variable = fit_out(cur.decl_vars);
				res.count    = fit_out(tail_clauses);
			end else if (!is_ws) begin
				fail_en   = 1'b1;
				fail_code = ERR_HDR_SYNTAX;
			end
		end

		if (fail_en) begin
			nxt.phase      = PH_ERR;
			nxt.err        = fail_code;
			res            = '0;
			res.ev         = EV_ERROR;
			res.error_code = fail_code;
		end
	end

endmodule

// File: design/dimacs_cnf_stream_parser_core.sv
`timescale 1ns / 1ps
// Top level of the DIMACS CNF stream parser: input register, parse state and
// result register around dcsp_step. Depends on dcsp_pkg and dcsp_step.
//
// Channel | Dir | Beat content
// s_*     | in  | tdata[7:0] data_byte, tlast at_end (end-of-input beat)
// m_*     | out | tuser[2:0] event_res; tdata variable, negated, count, error_code
//
// Every input beat yields exactly one output beat. The accepting edge loads the
// input register, and the step logic then moves it into the result register.
// Throughput is one beat per cycle while m_tready does not stall the output. A
// stall on m_tready holds the result register and then the input register; s_tready
// drops only when both are full. Reset clears the parse state to the start of the
// header area and empties both registers.
module dimacs_cnf_stream_parser_core import dcsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // at_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,   // [30:0] variable, [31] negated, [62:32] count,
	                               // [66:63] error_code, [71:67] zero
	output logic [2:0]  m_tuser    // [2:0] event_res
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          end_s1;
	parse_state_t  state_q;
	parse_state_t  state_nxt;
	parse_result_t res_nxt;
	parse_result_t res_q;
	logic          out_valid_q;
	logic          advance;

	// result register can take a new beat when empty or being drained
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	// input register: hold the beat until the step logic consumes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	dcsp_step u_step (
		.cur       (state_q),
		.data_byte (byte_s1),
		.at_end    (end_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// parse state and result valid advance together with the beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '{phase: PH_START, err: ERR_NONE, default: '0};
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				state_q <= state_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			res_q <= res_nxt;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = res_q.ev;
	assign m_tdata  = {5'd0, res_q.error_code, res_q.count, res_q.negated, res_q.variable};

endmodule

// File: design/dcsp_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the parser top level, with its bind statement.
// Depends on dcsp_pkg.
module dcsp_checker import dcsp_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [71:0] m_tdata,
	input logic [2:0]  m_tuser
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// error beats carry a code, all other beats carry none
	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ((m_tuser == EV_ERROR) == (m_tdata[66:63] != ERR_NONE)))
		else $error("error code does not match the event");

	// an empty result register always takes a beat
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

	// sign flag only on literal beats
	a_neg_lit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[31] |-> (m_tuser == EV_LIT))
		else $error("negated set outside literal beat");

	// an error beat, once taken, is followed by error beats with the same code
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && (m_tuser == EV_ERROR) ##1 m_tvalid |->
		(m_tuser == EV_ERROR) && (m_tdata[66:63] == $past(m_tdata[66:63])))
		else $error("error not sticky");

endmodule

bind dimacs_cnf_stream_parser_core dcsp_checker u_dcsp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
